### rtl/core/ump_packet_assembler_core_macros.svh
// assertion macros shared by the packet assembler rtl
// no dependencies; include by bare file name
`ifndef UMP_PACKET_ASSEMBLER_CORE_MACROS_SVH
`define UMP_PACKET_ASSEMBLER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define UMPPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("umppa assertion failed");

// next-cycle implication, disabled while reset is asserted
`define UMPPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("umppa assertion failed");

`endif

### rtl/core/umppa_pkg.sv
// types and constants for the ump packet assembler
// no dependencies
package umppa_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned COUNT_W = 3;
	localparam int unsigned PORT_W  = 5;

	localparam logic [3:0] MT_UTILITY = 4'h0;
	localparam logic [3:0] MT_STREAM  = 4'hF;
	localparam logic [PORT_W-1:0] BROADCAST_PORT = 5'd16;
	localparam logic [COUNT_W-1:0] VAR_EVENT_COUNT = 3'd4;

	// packet length in words, indexed by message type
	localparam logic [COUNT_W-1:0] LEN_TABLE [16] = '{
		3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd4, 3'd1, 3'd1,
		3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4
	};

	typedef struct packed {
		logic [WORD_W-1:0]  word0;
		logic [WORD_W-1:0]  word1;
		logic [WORD_W-1:0]  word2;
		logic [WORD_W-1:0]  word3;
		logic [COUNT_W-1:0] count;
		logic [PORT_W-1:0]  port;
		logic               var_event;
	} packet_t;

endpackage

### rtl/core/umppa_frame.sv
// framing state and per-word packet assembly
// depends on umppa_pkg
module umppa_frame import umppa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [WORD_W-1:0] word,
	input  logic              go,
	output logic              emit,
	output packet_t           packet
);

	logic [WORD_W-1:0]  held_q [3];
	logic [1:0]         held_cnt_q;
	logic [COUNT_W-1:0] pend_q;
	logic [PORT_W-1:0]  port_q;

	logic               start;
	logic [3:0]         msg_type;
	logic [COUNT_W-1:0] len;
	logic [COUNT_W-1:0] pend_next;
	logic [1:0]         cnt;
	logic [PORT_W-1:0]  port_cur;

	always_comb begin
		start     = (pend_q == '0);
		msg_type  = word[31:28];
		len       = start ? LEN_TABLE[msg_type] : pend_q;
		pend_next = len - 3'd1;
		cnt       = start ? 2'd0 : held_cnt_q;
		if (!start) begin
			port_cur = port_q;
		end else if (msg_type == MT_UTILITY || msg_type == MT_STREAM) begin
			port_cur = BROADCAST_PORT;
		end else begin
			port_cur = {1'b0, word[27:24]};
		end
		emit = (pend_next == '0);

		// held words below the current slot, this word in it, zero above
		packet.word0 = (cnt == 2'd0) ? word : held_q[0];
		packet.word1 = (cnt > 2'd1) ? held_q[1] : ((cnt == 2'd1) ? word : '0);
		packet.word2 = (cnt > 2'd2) ? held_q[2] : ((cnt == 2'd2) ? word : '0);
		packet.word3 = (cnt == 2'd3) ? word : '0;
		packet.count = {1'b0, cnt} + 3'd1;
		packet.port  = port_cur;
		packet.var_event = (packet.count == VAR_EVENT_COUNT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= '0;
			pend_q     <= '0;
			port_q     <= '0;
		end else if (go) begin
			pend_q     <= pend_next;
			port_q     <= port_cur;
			held_cnt_q <= emit ? 2'd0 : cnt + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go && !emit && cnt != 2'd3) begin
			held_q[cnt] <= word;
		end
	end

endmodule

### rtl/core/ump_packet_assembler_core.sv
// ump packet assembler: a packet reaches the outputs after the transfer of its last word
// (input register, then result register); one word is accepted every cycle while the
// result register drains, and a completed packet leaves at most one per cycle.
// arst_n clears the framing state and both valid flags; a packet starts at the next word.
// depends on umppa_pkg, umppa_frame and ump_packet_assembler_core_macros.svh
`include "ump_packet_assembler_core_macros.svh"

module ump_packet_assembler_core import umppa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               word_valid,
	output logic               word_stall,
	input  logic [WORD_W-1:0]  word_in,
	output logic               packet_valid,
	input  logic               packet_stall,
	output logic [WORD_W-1:0]  packet_word0,
	output logic [WORD_W-1:0]  packet_word1,
	output logic [WORD_W-1:0]  packet_word2,
	output logic [WORD_W-1:0]  packet_word3,
	output logic [COUNT_W-1:0] word_count,
	output logic [PORT_W-1:0]  port,
	output logic               variable_event
);

	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              go_s1;
	logic              emit_s1;
	packet_t           packet_s1;
	logic              out_valid_q;
	packet_t           out_q;
	logic              out_free;

	umppa_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.word   (word_s1),
		.go     (go_s1),
		.emit   (emit_s1),
		.packet (packet_s1)
	);

	// a non-final word never needs the result register
	assign out_free   = !out_valid_q || !packet_stall;
	assign go_s1      = valid_s1 && (!emit_s1 || out_free);
	assign word_stall = valid_s1 && !go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!word_stall) begin
			valid_s1 <= word_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!word_stall && word_valid) begin
			word_s1 <= word_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (!packet_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && emit_s1) begin
			out_q <= packet_s1;
		end
	end

	assign packet_valid   = out_valid_q;
	assign packet_word0   = out_q.word0;
	assign packet_word1   = out_q.word1;
	assign packet_word2   = out_q.word2;
	assign packet_word3   = out_q.word3;
	assign word_count     = out_q.count;
	assign port           = out_q.port;
	assign variable_event = out_q.var_event;

	`UMPPA_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !go_s1, valid_s1 && $stable(word_s1))
	`UMPPA_ASSERT_NOW(a_count_range, clk, arst_n, packet_valid, word_count != 3'd0 && word_count <= 3'd4)
	`UMPPA_ASSERT_NOW(a_var_event, clk, arst_n, packet_valid, variable_event == (word_count == 3'd4))
	`UMPPA_ASSERT_NOW(a_port_range, clk, arst_n, packet_valid, !port[4] || port[3:0] == 4'd0)
	`UMPPA_ASSERT_NOW(a_short_zero, clk, arst_n, packet_valid && word_count == 3'd1, packet_word1 == '0 && packet_word2 == '0 && packet_word3 == '0)

endmodule

### verif/ump_packet_assembler_core_test.sv
`timescale 1ns / 1ps
// self-checking testbench for ump_packet_assembler_core: drives ump word streams,
// predicts assembled packets and compares every packet field; depends on umppa_pkg
module ump_packet_assembler_core_test;
	import umppa_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned LONG_HOLD   = 300;

	// message types used by name in the directed part
	localparam logic [3:0] MT_SYSTEM   = 4'h1;
	localparam logic [3:0] MT_DATA64   = 4'h3;
	localparam logic [3:0] MT_DATA128  = 4'h5;
	localparam logic [3:0] MT_RSVD_96  = 4'hB;
	localparam logic [3:0] MT_FLEX     = 4'hD;

	// packet length in words per message type
	localparam logic [2:0] frame_len [16] = '{
		3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd4, 3'd1, 3'd1,
		3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               word_valid = 1'b0;
	logic               word_stall;
	logic [WORD_W-1:0]  word_in = '0;
	logic               packet_valid;
	logic               packet_stall = 1'b0;
	logic [WORD_W-1:0]  packet_word0;
	logic [WORD_W-1:0]  packet_word1;
	logic [WORD_W-1:0]  packet_word2;
	logic [WORD_W-1:0]  packet_word3;
	logic [COUNT_W-1:0] word_count;
	logic [PORT_W-1:0]  port;
	logic               variable_event;

	ump_packet_assembler_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.word_valid     (word_valid),
		.word_stall     (word_stall),
		.word_in        (word_in),
		.packet_valid   (packet_valid),
		.packet_stall   (packet_stall),
		.packet_word0   (packet_word0),
		.packet_word1   (packet_word1),
		.packet_word2   (packet_word2),
		.packet_word3   (packet_word3),
		.word_count     (word_count),
		.port           (port),
		.variable_event (variable_event)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// framing state of the predictor
	logic [WORD_W-1:0]  held_word [3];
	logic [1:0]         held_n = '0;
	logic [2:0]         words_left = '0;
	logic [PORT_W-1:0]  frame_port = '0;

	logic [WORD_W-1:0]  pending_words [$];
	packet_t            expected_packets [$];

	bit                 send_idle_on = 1'b0;
	bit                 recv_idle_on = 1'b0;
	bit                 hold_request = 1'b0;
	bit                 hold_served = 1'b0;
	bit                 word_taken = 1'b0;
	int unsigned        send_gap = 0;
	int unsigned        stall_left = 0;
	int unsigned        hold_left = 0;
	int unsigned        cycles = 0;
	int unsigned        words_sent = 0;
	int unsigned        packets_checked = 0;
	int unsigned        broadcast_seen = 0;
	int unsigned        long_packets_seen = 0;
	int unsigned        mismatches = 0;
	int unsigned        leftovers = 0;

	task automatic frame_word(input logic [WORD_W-1:0] w);
		logic [3:0] mt;
		packet_t    pkt;
		logic [WORD_W-1:0] slot [4];
		if (words_left == 3'd0) begin
			mt = w[31:28];
			words_left = frame_len[mt];
			held_n = 2'd0;
			if (mt == MT_UTILITY || mt == MT_STREAM)
				frame_port = BROADCAST_PORT;
			else
				frame_port = {1'b0, w[27:24]};
		end
		words_left = words_left - 3'd1;
		if (words_left != 3'd0) begin
			held_word[held_n] = w;
			held_n = held_n + 2'd1;
			return;
		end
		for (int k = 0; k < 4; k++) slot[k] = '0;
		for (int k = 0; k < held_n; k++) slot[k] = held_word[k];
		slot[held_n] = w;
		pkt.word0 = slot[0];
		pkt.word1 = slot[1];
		pkt.word2 = slot[2];
		pkt.word3 = slot[3];
		pkt.count = {1'b0, held_n} + 3'd1;
		pkt.port = frame_port;
		pkt.var_event = (pkt.count == VAR_EVENT_COUNT);
		expected_packets.push_back(pkt);
		held_n = 2'd0;
	endtask

	// queue one packet: header word, then continuation words (fixed or random)
	task automatic add_packet(input logic [3:0] mt, input logic [3:0] grp,
			input logic [23:0] body, input logic [WORD_W-1:0] fill, input bit rand_fill);
		pending_words.push_back({mt, grp, body});
		for (int k = 1; k < frame_len[mt]; k++)
			pending_words.push_back(rand_fill ? WORD_W'($urandom) : fill);
	endtask

	task automatic add_random(input int unsigned n_words);
		int unsigned target;
		target = pending_words.size() + n_words;
		while (pending_words.size() < target)
			add_packet(4'($urandom_range(0, 15)), 4'($urandom), 24'($urandom), '0, 1'b1);
	endtask

	task automatic drain;
		while (pending_words.size() != 0 || word_valid || expected_packets.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
			input logic [WORD_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s expected %h got %h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// word transfer: sample at the rising edge and feed the predictor
	always @(posedge clk) begin
		word_taken = arst_n && word_valid && !word_stall;
		if (word_taken) begin
			frame_word(word_in);
			words_sent++;
		end
	end

	// word driver
	always @(negedge clk) begin : drive_words
		logic              nv;
		logic [WORD_W-1:0] nw;
		nv = word_valid;
		nw = word_in;
		if (word_valid && word_taken)
			nv = 1'b0;
		if (!nv && arst_n) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (send_idle_on && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(0, 15);
			end else if (pending_words.size() != 0) begin
				nw = pending_words.pop_front();
				nv = 1'b1;
			end
		end
		word_valid <= nv;
		word_in <= nw;
	end

	// packet receiver stall
	always @(negedge clk) begin : drive_stall
		logic ns;
		if (hold_request && !hold_served) begin
			hold_left = LONG_HOLD;
			hold_served = 1'b1;
		end
		if (hold_left > 0) begin
			ns = 1'b1;
			hold_left--;
		end else if (stall_left > 0) begin
			ns = 1'b1;
			stall_left--;
		end else if (recv_idle_on && $urandom_range(0, 11) == 0) begin
			ns = 1'b1;
			stall_left = $urandom_range(0, 15);
		end else begin
			ns = 1'b0;
		end
		packet_stall <= ns;
	end

	// packet monitor
	always @(posedge clk) begin : watch_packets
		packet_t exp_pkt;
		if (arst_n && packet_valid && !packet_stall) begin
			if (expected_packets.size() == 0) begin
				$error("unexpected packet transfer, word0 %h", packet_word0);
				mismatches++;
			end else begin
				exp_pkt = expected_packets.pop_front();
				check_field("packet_word0", exp_pkt.word0, packet_word0);
				check_field("packet_word1", exp_pkt.word1, packet_word1);
				check_field("packet_word2", exp_pkt.word2, packet_word2);
				check_field("packet_word3", exp_pkt.word3, packet_word3);
				check_field("word_count", WORD_W'(exp_pkt.count), WORD_W'(word_count));
				check_field("port", WORD_W'(exp_pkt.port), WORD_W'(port));
				check_field("variable_event", WORD_W'(exp_pkt.var_event),
					WORD_W'(variable_event));
				packets_checked++;
				if (port == BROADCAST_PORT) broadcast_seen++;
				if (variable_event) long_packets_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("ump_packet_assembler_core_test: errors");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: groupless types with group bits set, all-zero and all-one words,
		// every packet length, continuation words that look like headers
		add_packet(MT_UTILITY, 4'hF, 24'hFFFFFF, '0, 1'b0);
		add_packet(MT_UTILITY, 4'h0, 24'h000000, '0, 1'b0);
		add_packet(MT_STREAM, 4'hF, 24'hFFFFFF, 32'hFFFFFFFF, 1'b0);
		add_packet(MT_STREAM, 4'h0, 24'h000000, 32'h00000000, 1'b0);
		add_packet(MT_SYSTEM, 4'hF, 24'h123456, '0, 1'b0);
		add_packet(MT_DATA128, 4'h0, 24'hA5A5A5, 32'h00000000, 1'b0);
		add_packet(MT_DATA64, 4'h7, 24'h5A5A5A, '0, 1'b1);
		add_packet(MT_RSVD_96, 4'h9, 24'hC0FFEE, 32'hF0000000, 1'b0);
		add_packet(MT_FLEX, 4'h3, 24'h0F0F0F, 32'h0FFFFFFF, 1'b0);
		drain();

		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
		add_random(300);
		drain();

		// long receiver hold-off while the sender keeps offering words
		send_idle_on = 1'b0;
		hold_request = 1'b1;
		add_random(40);
		drain();

		send_idle_on = 1'b1;
		add_random(680);
		drain();

		// closing stretch with no idling on either side
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		add_random(160);
		drain();
		repeat (8) @(posedge clk);

		leftovers = expected_packets.size();
		if (leftovers != 0)
			$error("%0d expected packets never arrived", leftovers);
		$display("%0d words in, %0d packets checked (%0d broadcast, %0d four-word)",
			words_sent, packets_checked, broadcast_seen, long_packets_seen);
		if (mismatches == 0 && leftovers == 0)
			$display("ump_packet_assembler_core_test: clean");
		else
			$display("ump_packet_assembler_core_test: errors");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/umppa_pkg.sv
rtl/core/umppa_frame.sv
rtl/core/ump_packet_assembler_core.sv
verif/ump_packet_assembler_core_test.sv
